[hw/rtl/lcoc_pkg.sv]
// ----------------------------------------------------------------------------
// lcoc_pkg: shared types and constants
// Configuration layout, register indexes and event codes for the counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lcoc_pkg;

	// field widths
	localparam int ANGLE_W   = 15;
	localparam int DIST_W    = 16;
	localparam int COOL_W    = 8;
	localparam int OCC_W     = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// saturation point of the elapsed-second counters
	localparam logic [COOL_W-1:0] ELAPSED_MAX = '1;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GATE_RANGE       = 3'd0,
		REG_ENTRY_ANGLE      = 3'd1,
		REG_EXIT_ANGLE       = 3'd2,
		REG_HALF_WIDTH       = 3'd3,
		REG_COOLDOWN_SECONDS = 3'd4,
		REG_SPOT_LIMIT       = 3'd5
	} reg_idx_t;

	// register reset values
	localparam logic [DIST_W-1:0]  RST_GATE_RANGE       = 16'd1500;
	localparam logic [ANGLE_W-1:0] RST_ENTRY_ANGLE      = 15'd5760;
	localparam logic [ANGLE_W-1:0] RST_EXIT_ANGLE       = 15'd17280;
	localparam logic [ANGLE_W-1:0] RST_HALF_WIDTH       = 15'd320;
	localparam logic [COOL_W-1:0]  RST_COOLDOWN_SECONDS = 8'd2;
	localparam logic [OCC_W-1:0]   RST_SPOT_LIMIT       = 10'd16;

	// event codes per line
	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_COUNTED = 2'd1,
		EV_IGNORED = 2'd2
	} ev_code_t;

	// configuration register set
	typedef struct packed {
		logic [DIST_W-1:0]  gate_range;
		logic [ANGLE_W-1:0] entry_angle;
		logic [ANGLE_W-1:0] exit_angle;
		logic [ANGLE_W-1:0] half_width;
		logic [COOL_W-1:0]  cooldown_seconds;
		logic [OCC_W-1:0]   spot_limit;
	} cfg_t;

	// per-line result of one request
	typedef struct packed {
		ev_code_t ev;
		logic     counted;
	} line_res_t;

endpackage

`default_nettype wire

[hw/rtl/line_crossing_occupancy_counter.sv]
// ----------------------------------------------------------------------------
// line_crossing_occupancy_counter: occupancy count from line crossings
// Path: an accepted request goes to the input register, then the result
// register. Throughput: one request per cycle while the receiver takes
// results, set by the combinational state update between the two registers.
// Reset: asynchronous, clears counters, window flags and handshake state;
// configuration returns to its default values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module line_crossing_occupancy_counter (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration
	input  wire logic                           cfg_we,
	input  wire logic [lcoc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lcoc_pkg::CFG_DAT_W-1:0] cfg_wdata,
	// request channel
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           kind,
	input  wire logic [lcoc_pkg::ANGLE_W-1:0]   angle,
	input  wire logic [lcoc_pkg::DIST_W-1:0]    distance,
	input  wire logic                           badge_recent,
	// result channel
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [1:0]                          entry_event,
	output logic [1:0]                          exit_event,
	output logic [lcoc_pkg::OCC_W-1:0]          occupancy
);

	lcoc_pkg::cfg_t      cfg;
	lcoc_pkg::line_res_t entry_res;
	lcoc_pkg::line_res_t exit_res;

	logic                         valid_s1;
	logic                         kind_s1;
	logic [lcoc_pkg::ANGLE_W-1:0] angle_s1;
	logic [lcoc_pkg::DIST_W-1:0]  distance_s1;
	logic                         badge_s1;

	logic                         out_valid_q;
	logic [1:0]                   entry_event_q;
	logic [1:0]                   exit_event_q;
	logic [lcoc_pkg::OCC_W-1:0]   occupancy_q;

	logic                         advance;
	logic                         sample_ok;
	logic [lcoc_pkg::OCC_W-1:0]   occ_mid;
	logic [lcoc_pkg::OCC_W-1:0]   occ_next;

	lcoc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// handshake: stage 1 moves on when the result register is free or drains
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1     <= kind;
			angle_s1    <= angle;
			distance_s1 <= distance;
			badge_s1    <= badge_recent;
		end
	end

	// distance gate for range samples
	assign sample_ok = !kind_s1 && (distance_s1 != '0)
		&& (distance_s1 <= cfg.gate_range);

	lcoc_line u_entry (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.is_tick    (kind_s1),
		.sample_ok  (sample_ok),
		.angle      (angle_s1),
		.line_angle (cfg.entry_angle),
		.window     (cfg.half_width),
		.cooldown   (cfg.cooldown_seconds),
		.badge      (badge_s1),
		.res        (entry_res)
	);

	lcoc_line u_exit (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.is_tick    (kind_s1),
		.sample_ok  (sample_ok),
		.angle      (angle_s1),
		.line_angle (cfg.exit_angle),
		.window     (cfg.half_width),
		.cooldown   (cfg.cooldown_seconds),
		.badge      (badge_s1),
		.res        (exit_res)
	);

	// occupancy update, entry before exit
	always_comb begin
		occ_mid = occupancy_q;
		if (entry_res.counted && (occupancy_q < cfg.spot_limit)) begin
			occ_mid = occupancy_q + 1'b1;
		end
		occ_next = occ_mid;
		if (exit_res.counted && (occ_mid != '0)) begin
			occ_next = occ_mid - 1'b1;
		end
	end

	// count state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupancy_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				occupancy_q <= occ_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			entry_event_q <= entry_res.ev;
			exit_event_q  <= exit_res.ev;
		end
	end

	assign out_valid   = out_valid_q;
	assign entry_event = entry_event_q;
	assign exit_event  = exit_event_q;
	assign occupancy   = occupancy_q;

endmodule

`default_nettype wire

[hw/rtl/lcoc_cfg.sv]
// ----------------------------------------------------------------------------
// lcoc_cfg: configuration registers
// Plain write port; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcoc_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [lcoc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lcoc_pkg::CFG_DAT_W-1:0] cfg_wdata,
	output lcoc_pkg::cfg_t                      cfg
);

	lcoc_pkg::cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gate_range       <= lcoc_pkg::RST_GATE_RANGE;
			cfg_q.entry_angle      <= lcoc_pkg::RST_ENTRY_ANGLE;
			cfg_q.exit_angle       <= lcoc_pkg::RST_EXIT_ANGLE;
			cfg_q.half_width       <= lcoc_pkg::RST_HALF_WIDTH;
			cfg_q.cooldown_seconds <= lcoc_pkg::RST_COOLDOWN_SECONDS;
			cfg_q.spot_limit       <= lcoc_pkg::RST_SPOT_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				lcoc_pkg::REG_GATE_RANGE: begin
					cfg_q.gate_range <= cfg_wdata;
				end
				lcoc_pkg::REG_ENTRY_ANGLE: begin
					cfg_q.entry_angle <= cfg_wdata[lcoc_pkg::ANGLE_W-1:0];
				end
				lcoc_pkg::REG_EXIT_ANGLE: begin
					cfg_q.exit_angle <= cfg_wdata[lcoc_pkg::ANGLE_W-1:0];
				end
				lcoc_pkg::REG_HALF_WIDTH: begin
					cfg_q.half_width <= cfg_wdata[lcoc_pkg::ANGLE_W-1:0];
				end
				lcoc_pkg::REG_COOLDOWN_SECONDS: begin
					cfg_q.cooldown_seconds <= cfg_wdata[lcoc_pkg::COOL_W-1:0];
				end
				lcoc_pkg::REG_SPOT_LIMIT: begin
					cfg_q.spot_limit <= cfg_wdata[lcoc_pkg::OCC_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[hw/rtl/lcoc_line.sv]
// ----------------------------------------------------------------------------
// lcoc_line: one line window
// Window test, inside flag, cooldown timer and event decision for one line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcoc_line (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	input  wire logic                         is_tick,
	input  wire logic                         sample_ok,
	input  wire logic [lcoc_pkg::ANGLE_W-1:0] angle,
	input  wire logic [lcoc_pkg::ANGLE_W-1:0] line_angle,
	input  wire logic [lcoc_pkg::ANGLE_W-1:0] window,
	input  wire logic [lcoc_pkg::COOL_W-1:0]  cooldown,
	input  wire logic                         badge,
	output lcoc_pkg::line_res_t               res
);

	logic                         inside_q;
	logic [lcoc_pkg::COOL_W-1:0]  elapsed_q;
	logic [lcoc_pkg::ANGLE_W-1:0] diff;
	logic                         in_win;
	logic                         fire;

	// plain absolute difference, no wrap
	always_comb begin
		if (angle >= line_angle) begin
			diff = angle - line_angle;
		end else begin
			diff = line_angle - angle;
		end
	end

	assign in_win = (diff < window);
	assign fire   = sample_ok && in_win && !inside_q && (elapsed_q >= cooldown);

	// event decision
	always_comb begin
		res.counted = fire && !badge;
		if (!fire) begin
			res.ev = lcoc_pkg::EV_NONE;
		end else if (badge) begin
			res.ev = lcoc_pkg::EV_IGNORED;
		end else begin
			res.ev = lcoc_pkg::EV_COUNTED;
		end
	end

	// window flag and elapsed-second timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q  <= 1'b0;
			elapsed_q <= '0;
		end else if (step) begin
			if (is_tick) begin
				if (elapsed_q != lcoc_pkg::ELAPSED_MAX) begin
					elapsed_q <= elapsed_q + 1'b1;
				end
			end else if (sample_ok) begin
				inside_q <= in_win;
				if (fire) begin
					elapsed_q <= '0;
				end
			end
		end
	end

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for line_crossing_occupancy_counter
// Drives ticks and range samples over valid/ready with random gaps and
// receiver stalls. A scoreboard predicts the window flags, cooldowns,
// event codes and occupancy for every request, then checks each result in
// order. The run covers directed corner cases, several register settings
// and a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import lcoc_pkg::*;

	localparam bit KIND_SAMPLE = 1'b0;
	localparam bit KIND_TICK   = 1'b1;

	// register indexes beyond the list, writes there must do nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int ANGLE_TOP   = 32767;

	// expected result of one request
	typedef struct {
		ev_code_t          entry_ev;
		ev_code_t          exit_ev;
		logic [OCC_W-1:0]  occ;
	} occ_result_t;

	// predictor of the counter and store of pending results
	class occupancy_scoreboard;
		cfg_t              cfg;
		logic [OCC_W-1:0]  count;
		bit                entry_in;
		bit                exit_in;
		logic [COOL_W-1:0] entry_secs;
		logic [COOL_W-1:0] exit_secs;
		occ_result_t       pending[$];
		int                errors;
		int                n_requests;
		int                n_ticks;
		int                n_gated;
		int                n_entry_ev[3];
		int                n_exit_ev[3];

		function new();
			cfg.gate_range       = RST_GATE_RANGE;
			cfg.entry_angle      = RST_ENTRY_ANGLE;
			cfg.exit_angle       = RST_EXIT_ANGLE;
			cfg.half_width       = RST_HALF_WIDTH;
			cfg.cooldown_seconds = RST_COOLDOWN_SECONDS;
			cfg.spot_limit       = RST_SPOT_LIMIT;
			count      = '0;
			entry_in   = 1'b0;
			exit_in    = 1'b0;
			entry_secs = '0;
			exit_secs  = '0;
			errors     = 0;
			n_requests = 0;
			n_ticks    = 0;
			n_gated    = 0;
			n_entry_ev = '{0, 0, 0};
			n_exit_ev  = '{0, 0, 0};
		endfunction

		// register write, upper data bits beyond a register are dropped
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
			case (idx)
				REG_GATE_RANGE:       cfg.gate_range       = val;
				REG_ENTRY_ANGLE:      cfg.entry_angle      = val[ANGLE_W-1:0];
				REG_EXIT_ANGLE:       cfg.exit_angle       = val[ANGLE_W-1:0];
				REG_HALF_WIDTH:       cfg.half_width       = val[ANGLE_W-1:0];
				REG_COOLDOWN_SECONDS: cfg.cooldown_seconds = val[COOL_W-1:0];
				REG_SPOT_LIMIT:       cfg.spot_limit       = val[OCC_W-1:0];
				default: ;
			endcase
		endfunction

		// one line window: flag, cooldown and count update
		function ev_code_t judge_line(logic [ANGLE_W-1:0] ang, logic [ANGLE_W-1:0] line_ang,
				inout bit in_win, inout logic [COOL_W-1:0] secs, input bit badge,
				input bit is_entry);
			ev_code_t ev;
			int       diff;
			ev = EV_NONE;
			diff = (ang >= line_ang) ? int'(ang) - int'(line_ang) : int'(line_ang) - int'(ang);
			if (diff < int'(cfg.half_width)) begin
				if (!in_win) begin
					if (secs >= cfg.cooldown_seconds) begin
						if (badge) begin
							ev = EV_IGNORED;
						end else begin
							ev = EV_COUNTED;
							if (is_entry) begin
								if (count < cfg.spot_limit)
									count = count + 1'b1;
							end else if (count != '0) begin
								count = count - 1'b1;
							end
						end
						secs = '0;
					end
					in_win = 1'b1;
				end
			end else begin
				in_win = 1'b0;
			end
			return ev;
		endfunction

		// accepted request: work out the result it causes
		function void note_request(bit is_tick, logic [ANGLE_W-1:0] ang,
				logic [DIST_W-1:0] range_mm, bit badge);
			occ_result_t r;
			r.entry_ev = EV_NONE;
			r.exit_ev  = EV_NONE;
			n_requests++;
			if (is_tick) begin
				if (entry_secs != ELAPSED_MAX)
					entry_secs = entry_secs + 1'b1;
				if (exit_secs != ELAPSED_MAX)
					exit_secs = exit_secs + 1'b1;
				n_ticks++;
			end else if (range_mm != '0 && range_mm <= cfg.gate_range) begin
				r.entry_ev = judge_line(ang, cfg.entry_angle, entry_in, entry_secs, badge, 1'b1);
				r.exit_ev  = judge_line(ang, cfg.exit_angle, exit_in, exit_secs, badge, 1'b0);
			end else begin
				n_gated++;
			end
			r.occ = count;
			n_entry_ev[r.entry_ev]++;
			n_exit_ev[r.exit_ev]++;
			pending.push_back(r);
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		// accepted result against the oldest expectation
		task check_result(logic [1:0] ev_in, logic [1:0] ev_out, logic [OCC_W-1:0] occ);
			occ_result_t r;
			if (pending.size() == 0) begin
				report($sformatf("result %0d/%0d/%0d with no request waiting",
					ev_in, ev_out, occ));
			end else begin
				r = pending.pop_front();
				if (ev_in !== r.entry_ev)
					report($sformatf("entry_event %0d, expected %0d", ev_in, r.entry_ev));
				if (ev_out !== r.exit_ev)
					report($sformatf("exit_event %0d, expected %0d", ev_out, r.exit_ev));
				if (occ !== r.occ)
					report($sformatf("occupancy %0d, expected %0d", occ, r.occ));
			end
		endtask
	endclass

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DAT_W-1:0]  cfg_wdata    = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic                  kind         = 1'b0;
	logic [ANGLE_W-1:0]    angle        = '0;
	logic [DIST_W-1:0]     distance     = '0;
	logic                  badge_recent = 1'b0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	logic [1:0]            entry_event;
	logic [1:0]            exit_event;
	logic [OCC_W-1:0]      occupancy;

	occupancy_scoreboard sb = new();

	bit tx_idle      = 1'b1;
	bit rx_idle      = 1'b1;
	bit hold_request = 1'b0;
	int tick_pct     = 25;
	int n_settings   = 0;

	line_crossing_occupancy_counter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.angle        (angle),
		.distance     (distance),
		.badge_recent (badge_recent),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.entry_event  (entry_event),
		.exit_event   (exit_event),
		.occupancy    (occupancy)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// offer one request, after a random gap if tx_idle is set, and hold it until accepted
	task automatic send_item(bit k, logic [ANGLE_W-1:0] a, logic [DIST_W-1:0] d, bit b);
		int gap;
		gap = tx_idle ? $urandom_range(0, 19) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		kind         <= k;
		angle        <= a;
		distance     <= d;
		badge_recent <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_request(k, a, d, b);
	endtask

	// stop offering and let every pending result come back
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic close_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// write the whole register set, junk in the unused upper data bits
	task automatic apply_setting(cfg_t s);
		logic [CFG_DAT_W-1:0] junk;
		junk = CFG_DAT_W'($urandom);
		write_reg(REG_GATE_RANGE, s.gate_range);
		write_reg(REG_ENTRY_ANGLE, {junk[15], s.entry_angle});
		write_reg(REG_EXIT_ANGLE, {junk[14], s.exit_angle});
		write_reg(REG_HALF_WIDTH, {junk[13], s.half_width});
		write_reg(REG_COOLDOWN_SECONDS, {junk[7:0], s.cooldown_seconds});
		write_reg(REG_SPOT_LIMIT, {junk[5:0], s.spot_limit});
		close_writes();
		n_settings++;
	endtask

	function automatic cfg_t pick_setting(int p);
		cfg_t s;
		case (p)
			0: begin
				s.gate_range       = 16'd65535;
				s.entry_angle      = 15'd0;
				s.exit_angle       = 15'd23039;
				s.half_width       = 15'd1;
				s.cooldown_seconds = 8'd0;
				s.spot_limit       = 10'd1023;
			end
			1: begin
				s.gate_range       = 16'd1;
				s.entry_angle      = 15'd23039;
				s.exit_angle       = 15'd0;
				s.half_width       = 15'd23040;
				s.cooldown_seconds = 8'd1;
				s.spot_limit       = 10'd0;
			end
			default: begin
				s.gate_range       = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
					: 16'($urandom_range(200, 6000));
				s.entry_angle      = 15'($urandom_range(0, 23039));
				s.exit_angle       = 15'($urandom_range(0, 23039));
				s.half_width       = 15'($urandom_range(1, 3000));
				s.cooldown_seconds = 8'($urandom_range(0, 3));
				s.spot_limit       = ($urandom_range(0, 4) == 0) ? 10'd1023
					: 10'($urandom_range(0, 20));
			end
		endcase
		return s;
	endfunction

	// random requests, mostly near the line windows and within range
	task automatic send_random(int n);
		bit                 k;
		bit                 b;
		logic [ANGLE_W-1:0] a;
		logic [DIST_W-1:0]  d;
		int                 sel;
		int                 base;
		int                 span;
		int                 v;
		int                 w;
		int                 trig;
		repeat (n) begin
			k    = ($urandom_range(0, 99) < tick_pct);
			w    = int'(sb.cfg.half_width);
			trig = int'(sb.cfg.gate_range);
			span = 2 * w + 4;
			sel  = $urandom_range(0, 99);
			base = (sel < 40) ? int'(sb.cfg.entry_angle) :
				(sel < 80) ? int'(sb.cfg.exit_angle) : -1;
			if (base < 0) begin
				a = 15'($urandom_range(0, ANGLE_TOP));
			end else begin
				case ($urandom_range(0, 7))
					0: v = base - w;
					1: v = base + w;
					2: v = base - w + 1;
					3: v = base + w - 1;
					default: v = base + $urandom_range(0, 2 * span) - span;
				endcase
				if (v < 0)
					v = 0;
				if (v > ANGLE_TOP)
					v = ANGLE_TOP;
				a = 15'(v);
			end
			sel = $urandom_range(0, 99);
			if (sel < 70 && trig > 0)
				d = 16'($urandom_range(1, trig));
			else if (sel < 78)
				d = '0;
			else if (sel < 86 && trig < 65535)
				d = 16'($urandom_range(trig + 1, 65535));
			else
				d = 16'($urandom_range(0, 65535));
			b = ($urandom_range(0, 3) == 0);
			send_item(k, a, d, b);
		end
	endtask

	// result side: random stalls when rx_idle is set, one long hold-off when asked
	initial begin : receiver
		int stall;
		wait (arst_n);
		forever begin
			stall = rx_idle ? $urandom_range(0, 19) : 0;
			if (hold_request) begin
				hold_request = 1'b0;
				stall = HOLD_CYCLES;
			end
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_result(entry_event, exit_event, occupancy);
		end
	end

	// watchdog on cycles without any accepted request or result
	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d results pending",
					quiet, sb.pending.size());
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// stimulus
	initial begin : stimulus
		cfg_t s;
		int   p;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed, reset settings: cooldown pending, boundaries, gating, badge
		send_item(KIND_SAMPLE, 15'd5760, 16'd800, 1'b0);
		send_item(KIND_SAMPLE, 15'd0, 16'd800, 1'b0);
		send_item(KIND_TICK, 15'd0, 16'd0, 1'b0);
		send_item(KIND_TICK, 15'd0, 16'd0, 1'b0);
		send_item(KIND_SAMPLE, 15'd5760, 16'd1500, 1'b0);
		send_item(KIND_SAMPLE, 15'd5761, 16'd1, 1'b0);
		send_item(KIND_SAMPLE, 15'd17599, 16'd1, 1'b0);
		send_item(KIND_SAMPLE, 15'd5760, 16'd0, 1'b0);
		send_item(KIND_SAMPLE, 15'd5760, 16'd1501, 1'b0);
		send_item(KIND_SAMPLE, 15'd5760, 16'd65535, 1'b1);
		send_item(KIND_TICK, 15'd0, 16'd0, 1'b0);
		send_item(KIND_TICK, 15'd0, 16'd0, 1'b0);
		send_item(KIND_SAMPLE, 15'd6080, 16'd100, 1'b0);
		send_item(KIND_SAMPLE, 15'd5441, 16'd100, 1'b1);
		send_item(KIND_SAMPLE, 15'd32767, 16'd10, 1'b0);
		send_item(KIND_SAMPLE, 15'd16960, 16'd100, 1'b0);
		send_item(KIND_SAMPLE, 15'd17280, 16'd100, 1'b1);
		send_item(KIND_TICK, 15'd32767, 16'd65535, 1'b1);
		wait_idle();

		// overlapping windows: entry judged before exit on one sample
		s.gate_range       = 16'd65535;
		s.entry_angle      = 15'd0;
		s.exit_angle       = 15'd23039;
		s.half_width       = 15'd12000;
		s.cooldown_seconds = 8'd0;
		s.spot_limit       = 10'd1023;
		apply_setting(s);
		send_item(KIND_SAMPLE, 15'd11600, 16'd9, 1'b0);
		send_item(KIND_SAMPLE, 15'd0, 16'd9, 1'b0);
		send_item(KIND_SAMPLE, 15'd23039, 16'd9, 1'b0);
		wait_idle();

		// count bounds, then a lowered limit below the count
		s.half_width = 15'd8000;
		s.spot_limit = 10'd1;
		apply_setting(s);
		send_item(KIND_SAMPLE, 15'd0, 16'd9, 1'b0);
		send_item(KIND_SAMPLE, 15'd11600, 16'd9, 1'b0);
		send_item(KIND_SAMPLE, 15'd0, 16'd9, 1'b0);
		wait_idle();
		write_reg(REG_SPOT_LIMIT, 16'd0);
		write_reg(REG_SPARE_A, 16'($urandom));
		write_reg(REG_SPARE_B, 16'($urandom));
		close_writes();
		send_item(KIND_SAMPLE, 15'd11600, 16'd9, 1'b0);
		send_item(KIND_SAMPLE, 15'd0, 16'd9, 1'b0);
		send_item(KIND_SAMPLE, 15'd23039, 16'd9, 1'b0);
		send_item(KIND_SAMPLE, 15'd11600, 16'd9, 1'b0);
		send_item(KIND_SAMPLE, 15'd23039, 16'd9, 1'b0);
		wait_idle();

		// random phases, each with its own setting and idle mix
		for (p = 0; p < 8; p++) begin
			tx_idle = ((p & 1) == 0);
			rx_idle = ((p & 2) == 0);
			apply_setting(pick_setting(p));
			if (p == 2) begin
				// receiver holds off while requests keep coming
				tx_idle      = 1'b0;
				hold_request = 1'b1;
			end
			send_random(170);
			wait_idle();
		end

		// long cooldown, ticks run the elapsed counters into saturation
		tx_idle            = 1'b0;
		rx_idle            = 1'b0;
		tick_pct           = 85;
		s.gate_range       = 16'd4000;
		s.entry_angle      = 15'd3000;
		s.exit_angle       = 15'd9000;
		s.half_width       = 15'd400;
		s.cooldown_seconds = 8'd255;
		s.spot_limit       = 10'd1023;
		apply_setting(s);
		send_random(330);
		wait_idle();
		repeat (10) @(posedge clk);

		$display("run: %0d requests (%0d ticks, %0d gated samples) over %0d settings",
			sb.n_requests, sb.n_ticks, sb.n_gated, n_settings);
		$display("events: entry %0d counted %0d ignored, exit %0d counted %0d ignored",
			sb.n_entry_ev[EV_COUNTED], sb.n_entry_ev[EV_IGNORED],
			sb.n_exit_ev[EV_COUNTED], sb.n_exit_ev[EV_IGNORED]);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/lcoc_pkg.sv
hw/rtl/lcoc_cfg.sv
hw/rtl/lcoc_line.sv
hw/rtl/line_crossing_occupancy_counter.sv
tb/tb_top.sv
